// ----- rtl/core/lrucb_pkg.sv -----
package lrucb_pkg;

  localparam int SLOTS = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int MIB_UNIT = 1024;
  localparam int BYTES_W = 37;

  localparam logic [2:0] REQ_PUT = 3'd0;
  localparam logic [2:0] REQ_GET = 3'd1;
  localparam logic [2:0] REQ_CONTAINS = 3'd2;
  localparam logic [2:0] REQ_REMOVE = 3'd3;
  localparam logic [2:0] REQ_CLEAR = 3'd4;

  localparam logic CFG_BUDGET = 1'b0;
  localparam logic CFG_ENTRIES = 1'b1;

  typedef struct packed {
    logic [2:0] req_type;
    logic signed [63:0] img_key;
    logic [15:0] img_width;
    logic [15:0] img_height;
  } req_t;

  typedef struct packed {
    logic ok;
    logic [15:0] res_width;
    logic [15:0] res_height;
    logic [4:0] entry_count;
    logic [35:0] memory_bytes;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_LOOK, ST_DISPATCH, ST_EVSCAN, ST_EVDROP,
    ST_FREESCAN, ST_INSERT, ST_DONE
  } state_t;

  // datapath commands
  typedef struct packed {
    logic load;        // latch request and its size
    logic scan_clr;    // reset scan pointer and the LRU-pick and free-slot flags
    logic scan_step;   // advance scan one slot
    logic hit_upd;     // act on lookup result (get/contains/remove/put hit)
    logic clear_all;
    logic drop_old;    // drop LRU pick
    logic insert;      // store into chosen slot
    logic respond;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic reject;      // put zero size or over limit
    logic found;
    logic pick_ok;     // LRU pick valid
    logic over;        // bytes_used + need > limit
    logic free_ok;     // free slot found
  } sts_t;

endpackage

// ----- rtl/core/lrucb_ctrl.sv -----
module lrucb_ctrl
  import lrucb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [2:0] req_type,
  output logic       busy,
  output cmd_t       cmd,
  input  sts_t       sts
);

  state_t state, state_next;
  logic [2:0] req;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      req <= REQ_PUT;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && start) req <= req_type;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_CHECK;
      ST_CHECK: begin
        if (req == REQ_CLEAR || req > REQ_CLEAR) state_next = ST_DISPATCH;
        else if (req == REQ_PUT && sts.reject) state_next = ST_DONE;
        else state_next = ST_LOOK;
      end
      ST_LOOK: if (sts.scan_end) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        if (req == REQ_PUT && !sts.found) state_next = ST_EVSCAN;
        else state_next = ST_DONE;
      end
      ST_EVSCAN: begin
        if (!sts.over) state_next = ST_FREESCAN;
        else if (sts.scan_end) state_next = ST_EVDROP;
      end
      ST_EVDROP: state_next = sts.pick_ok ? ST_EVSCAN : ST_FREESCAN;
      ST_FREESCAN: if (sts.scan_end) state_next = ST_INSERT;
      ST_INSERT: state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        cmd.load = start;
        cmd.scan_clr = start;
      end
      ST_CHECK: cmd.scan_clr = 1'b1;
      ST_LOOK: cmd.scan_step = 1'b1;
      ST_DISPATCH: begin
        cmd.scan_clr = 1'b1;
        if (req == REQ_CLEAR) cmd.clear_all = 1'b1;
        else if (req <= REQ_REMOVE) cmd.hit_upd = 1'b1;
      end
      ST_EVSCAN: cmd.scan_step = sts.over;
      ST_EVDROP: begin
        cmd.drop_old = 1'b1;
        cmd.scan_clr = 1'b1;
      end
      ST_FREESCAN: cmd.scan_step = 1'b1;
      ST_INSERT: cmd.insert = 1'b1;
      ST_DONE: cmd.respond = 1'b1;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_busy_idle: assert property (@(posedge clk) disable iff (rst)
    busy == (state != ST_IDLE)) else $error("busy mismatch");
  a_respond_done: assert property (@(posedge clk) disable iff (rst)
    cmd.respond |=> state == ST_IDLE) else $error("respond not last");
  a_start_ack: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("start not taken");
`endif

endmodule

// ----- rtl/core/lrucb_dp.sv -----
module lrucb_dp
  import lrucb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  req_t        req,
  input  logic [11:0] budget_mb,
  input  logic [4:0]  entries_in_use,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        result_valid,
  output rsp_t        result
);

  logic [SLOTS-1:0] vld;
  logic [63:0] key_m [SLOTS];
  logic [15:0] wid_m [SLOTS];
  logic [15:0] hgt_m [SLOTS];
  logic [63:0] stamp_m [SLOTS];
  logic [63:0] use_counter;
  logic [BYTES_W-1:0] bytes_used;
  logic [31:0] hits, misses;

  req_t r;
  logic [33:0] need;
  logic [31:0] prod;
  logic [BYTES_W-1:0] limit;
  logic [CNT_W-1:0] ptr;
  logic [CNT_W-1:0] n;
  logic found;
  logic [SLOT_W-1:0] fslot;
  logic pick_ok;
  logic [SLOT_W-1:0] pick;
  logic [63:0] pick_stamp;
  logic free_ok;
  logic [SLOT_W-1:0] free_slot;
  logic ok;
  logic [15:0] ow, oh;

  logic [SLOT_W-1:0] cur;
  logic [SLOT_W-1:0] ins;
  logic [CNT_W-1:0] cnt;
  logic [SLOT_W-1:0] osel;
  logic [31:0] oprod;
  logic [33:0] old_bytes;

  assign n = (entries_in_use > 5'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(entries_in_use);
  assign cur = ptr[SLOT_W-1:0];
  assign limit = BYTES_W'(budget_mb) << 20;
  assign prod = r.img_width * r.img_height;
  assign need = {prod, 2'b00};
  assign ins = free_ok ? free_slot : pick;

  // size of the slot being dropped or resized
  assign osel = (cmd.drop_old || cmd.insert) ? pick : fslot;
  assign oprod = wid_m[osel] * hgt_m[osel];
  assign old_bytes = {oprod, 2'b00};

  assign sts.scan_end = (ptr + 1'b1 >= n) || (n == '0);
  assign sts.reject = (r.img_width == '0) || (r.img_height == '0) ||
                      (BYTES_W'(need) > limit);
  assign sts.found = found;
  assign sts.pick_ok = pick_ok;
  assign sts.over = (bytes_used + BYTES_W'(need)) > limit;
  assign sts.free_ok = free_ok;

  always_comb begin
    cnt = '0;
    for (int i = 0; i < SLOTS; i++)
      if (vld[i] && CNT_W'(i) < n) cnt = cnt + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      use_counter <= '0;
      bytes_used <= '0;
      hits <= '0;
      misses <= '0;
      result_valid <= 1'b0;
      ptr <= '0;
      found <= 1'b0;
      pick_ok <= 1'b0;
      free_ok <= 1'b0;
    end else begin
      result_valid <= cmd.respond;
      if (cmd.load) begin
        r <= req;
        ok <= 1'b0;
        ow <= '0;
        oh <= '0;
      end
      if (cmd.scan_clr) begin
        ptr <= '0;
        pick_ok <= 1'b0;
        free_ok <= 1'b0;
      end
      if (cmd.load) begin
        found <= 1'b0;
        fslot <= '0;
      end
      if (cmd.scan_step && n != '0) begin
        ptr <= ptr + 1'b1;
        if (vld[cur] && key_m[cur] == r.img_key && !found) begin
          found <= 1'b1;
          fslot <= cur;
        end
        if (vld[cur] && (!pick_ok || stamp_m[cur] < pick_stamp)) begin
          pick_ok <= 1'b1;
          pick <= cur;
          pick_stamp <= stamp_m[cur];
        end
        if (!vld[cur] && !free_ok) begin
          free_ok <= 1'b1;
          free_slot <= cur;
        end
      end
      if (cmd.hit_upd && found) begin
        ok <= 1'b1;
        unique case (r.req_type)
          REQ_PUT: begin
            stamp_m[fslot] <= use_counter + 64'd2;
            use_counter <= use_counter + 64'd2;
            bytes_used <= bytes_used - BYTES_W'(old_bytes) + BYTES_W'(need);
            wid_m[fslot] <= r.img_width;
            hgt_m[fslot] <= r.img_height;
          end
          REQ_GET: begin
            stamp_m[fslot] <= use_counter + 64'd1;
            use_counter <= use_counter + 64'd1;
            if (hits != '1) hits <= hits + 1'b1;
            ow <= wid_m[fslot];
            oh <= hgt_m[fslot];
          end
          REQ_REMOVE: begin
            vld[fslot] <= 1'b0;
            bytes_used <= bytes_used - BYTES_W'(old_bytes);
          end
          default: ;
        endcase
      end
      if (cmd.hit_upd && !found && r.req_type == REQ_GET && misses != '1)
        misses <= misses + 1'b1;
      if (cmd.clear_all) begin
        vld <= '0;
        bytes_used <= '0;
        ok <= 1'b1;
      end
      if (cmd.drop_old && pick_ok) begin
        vld[pick] <= 1'b0;
        bytes_used <= bytes_used - BYTES_W'(old_bytes);
      end
      if (cmd.insert && (free_ok || pick_ok)) begin
        key_m[ins] <= r.img_key;
        wid_m[ins] <= r.img_width;
        hgt_m[ins] <= r.img_height;
        stamp_m[ins] <= use_counter + 64'd1;
        use_counter <= use_counter + 64'd1;
        vld[ins] <= 1'b1;
        ok <= 1'b1;
        if (free_ok) bytes_used <= bytes_used + BYTES_W'(need);
        else bytes_used <= bytes_used - BYTES_W'(old_bytes) + BYTES_W'(need);
      end
    end
  end

  always_comb begin
    result.ok = ok;
    result.res_width = ow;
    result.res_height = oh;
    result.entry_count = 5'(cnt);
    result.memory_bytes = bytes_used[35:0];
    result.hit_count = hits;
    result.miss_count = misses;
  end

`ifndef SYNTHESIS
  a_ins_target: assert property (@(posedge clk) disable iff (rst)
    (cmd.insert && (free_ok || pick_ok)) |=> vld[$past(ins)])
    else $error("insert lost");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_all |=> (vld == '0 && bytes_used == '0)) else $error("clear");
  a_hits_mono: assert property (@(posedge clk) disable iff (rst)
    hits >= $past(hits) || $past(rst)) else $error("hits went down");
`endif

endmodule

// ----- rtl/core/lru_cache_with_byte_budget.sv -----
// Image metadata cache, LRU replacement under a byte budget.
// Request channel: present req (a req_t word) with start; it is taken on a
// clock edge where start is high and busy is low. busy stays high from the
// cycle after that edge and is low again in the cycle in which the result is shown.
// Result: result is valid for exactly one cycle with result_valid high.
// The receiver cannot stall; it must take the word in that cycle.
// Config: cfg_valid/cfg_ready write channel, cfg_index 0 = budget_mb,
// 1 = entries_in_use. cfg_ready is high while the block is idle.
// Passes: n = entries_in_use, saturated at SLOTS. A get/contains/remove
// runs a lookup pass; clear and unknown codes run no pass, and a put with
// a zero dimension or a size over the budget is rejected without one. A
// put runs a lookup pass and, on a miss, one more full LRU pass for every
// budget eviction, then a free-slot pass. A new word is taken only once
// the result is shown. All passes walk the slot table one slot per cycle
// in the datapath.
// Reset: all slots invalid, counters and byte total zero, budget 64 MiB,
// 16 slots in use. Slot contents are not cleared.
module lru_cache_with_byte_budget
  import lrucb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  output logic        result_valid,
  output rsp_t        result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;
  logic [11:0] budget_mb;
  logic [4:0] entries_in_use;

  // config is only written while idle
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      budget_mb <= 12'd64;
      entries_in_use <= 5'(SLOTS);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BUDGET: budget_mb <= cfg_data;
        CFG_ENTRIES: entries_in_use <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  lrucb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .req_type(req.req_type),
    .busy(busy), .cmd(cmd), .sts(sts)
  );

  lrucb_dp u_dp (
    .clk(clk), .rst(rst), .req(req), .budget_mb(budget_mb),
    .entries_in_use(entries_in_use), .cmd(cmd), .sts(sts),
    .result_valid(result_valid), .result(result)
  );

`ifndef SYNTHESIS
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("double result");
  a_busy_res: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy) else $error("result while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !result_valid) else $error("early result");
`endif

endmodule

// ----- bench/tb_lru_cache_with_byte_budget.sv -----
`timescale 1ns / 1ps

module tb_lru_cache_with_byte_budget;
  import lrucb_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 400;  // worst put: lookup, 16 evictions, free scan
  localparam int NKEYS = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  req_t        req = '0;
  logic        result_valid;
  rsp_t        result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_BUDGET;
  logic [11:0] cfg_data = '0;

  lru_cache_with_byte_budget dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Cache shadow: slot table, counters and registers as the block sees them
  // ---------------------------------------------------------------------
  logic [11:0]     sh_budget = 12'd64;
  logic [4:0]      sh_entries = 5'd16;
  bit              sh_valid[SLOTS];
  logic [63:0]     sh_key[SLOTS];
  logic [15:0]     sh_w[SLOTS];
  logic [15:0]     sh_h[SLOTS];
  longint unsigned sh_stamp[SLOTS];
  longint unsigned sh_clock = 0;
  longint unsigned sh_bytes = 0;   // 37 bits wide in the block
  logic [31:0]     sh_hits = '0;
  logic [31:0]     sh_misses = '0;

  req_t  pending_words[$];   // request words not yet handed to the block
  rsp_t  expected_rsp[$];    // predicted response words, oldest first
  logic signed [63:0] key_pool[NKEYS];

  int  idle_pct = 0;
  bit  taken = 1'b0;         // request word accepted at the last rising edge
  int  cfg_writes = 0;
  int  mismatches = 0;
  int  cycles = 0;

  // Slots scanned: entries_in_use saturated at SLOTS.
  function automatic int scan_n();
    return (sh_entries > SLOTS) ? SLOTS : int'(sh_entries);
  endfunction

  function automatic longint unsigned img_bytes(logic [15:0] w, logic [15:0] h);
    longint unsigned s;
    s = longint'(w) * longint'(h) * 4;
    return s;
  endfunction

  // Lowest scanned slot holding the key, or -1.
  function automatic int find_key(logic [63:0] k);
    for (int i = 0; i < scan_n(); i++)
      if (sh_valid[i] && sh_key[i] == k) return i;
    return -1;
  endfunction

  // Least recently used valid scanned slot; ties go to the lower index.
  function automatic int lru_slot();
    int pick;
    pick = -1;
    for (int i = 0; i < scan_n(); i++)
      if (sh_valid[i] && (pick < 0 || sh_stamp[i] < sh_stamp[pick])) pick = i;
    return pick;
  endfunction

  function automatic void drop(int i);
    sh_bytes -= img_bytes(sh_w[i], sh_h[i]);
    sh_valid[i] = 1'b0;
  endfunction

  function automatic bit cache_put(logic [63:0] k, logic [15:0] w, logic [15:0] h);
    longint unsigned lim, need;
    int s;
    lim = longint'(sh_budget) * MIB_UNIT * MIB_UNIT;
    if (w == 0 || h == 0) return 1'b0;
    need = img_bytes(w, h);
    if (need > lim) return 1'b0;
    s = find_key(k);
    if (s >= 0) begin
      // present key: resize in place, no eviction, use clock advanced by two
      sh_clock++;
      sh_bytes = sh_bytes - img_bytes(sh_w[s], sh_h[s]) + need;
      sh_w[s] = w;
      sh_h[s] = h;
      sh_clock++;
      sh_stamp[s] = sh_clock;
      return 1'b1;
    end
    while (sh_bytes + need > lim) begin
      s = lru_slot();
      if (s < 0) break;
      drop(s);
    end
    s = -1;
    for (int i = 0; i < scan_n(); i++)
      if (!sh_valid[i]) begin
        s = i;
        break;
      end
    if (s < 0) begin
      s = lru_slot();
      if (s < 0) return 1'b0;   // nothing scanned at all
      drop(s);
    end
    sh_key[s] = k;
    sh_w[s] = w;
    sh_h[s] = h;
    sh_clock++;
    sh_stamp[s] = sh_clock;
    sh_valid[s] = 1'b1;
    sh_bytes += need;
    return 1'b1;
  endfunction

  // Apply one request word to the shadow and return the response word.
  function automatic rsp_t cache_request(req_t r);
    rsp_t e;
    int s;
    int cnt;
    e = '0;
    cnt = 0;
    case (r.req_type)
      REQ_PUT: e.ok = cache_put(r.img_key, r.img_width, r.img_height);
      REQ_GET: begin
        s = find_key(r.img_key);
        if (s >= 0) begin
          sh_clock++;
          sh_stamp[s] = sh_clock;
          if (sh_hits != '1) sh_hits++;
          e.ok = 1'b1;
          e.res_width = sh_w[s];
          e.res_height = sh_h[s];
        end else if (sh_misses != '1) begin
          sh_misses++;
        end
      end
      REQ_CONTAINS: e.ok = (find_key(r.img_key) >= 0);
      REQ_REMOVE: begin
        s = find_key(r.img_key);
        if (s >= 0) begin
          drop(s);
          e.ok = 1'b1;
        end
      end
      REQ_CLEAR: begin
        // all slots, not only the scanned ones
        for (int i = 0; i < SLOTS; i++) sh_valid[i] = 1'b0;
        sh_bytes = 0;
        e.ok = 1'b1;
      end
      default: ;  // unknown code: no change
    endcase
    for (int i = 0; i < scan_n(); i++)
      if (sh_valid[i]) cnt++;
    e.entry_count = cnt[4:0];
    e.memory_bytes = sh_bytes[35:0];
    e.hit_count = sh_hits;
    e.miss_count = sh_misses;
    return e;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: inputs move on the falling edge
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst && (!start || taken)) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        req <= pending_words.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: responses checked, requests and register writes predicted
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    rsp_t e;
    if (!rst) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("== FAIL ==");
        $finish;
      end
      if (result_valid) begin
        if (expected_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response word %p", result);
        end else begin
          e = expected_rsp.pop_front();
          if (result.ok !== e.ok || result.res_width !== e.res_width ||
              result.res_height !== e.res_height ||
              result.entry_count !== e.entry_count ||
              result.memory_bytes !== e.memory_bytes ||
              result.hit_count !== e.hit_count ||
              result.miss_count !== e.miss_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("response mismatch at cycle %0d\n  exp %p\n  got %p",
                       cycles, e, result);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BUDGET) sh_budget = cfg_data;
        else sh_entries = cfg_data[4:0];
        cfg_writes++;
      end
      taken = start && !busy;
      if (taken) expected_rsp.push_back(cache_request(req));
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  function automatic req_t mk(logic [2:0] op, logic signed [63:0] id,
                              logic [15:0] w, logic [15:0] h);
    req_t r;
    r.req_type = op;
    r.img_key = id;
    r.img_width = w;
    r.img_height = h;
    return r;
  endfunction

  // Mostly small images so that several fit; a few full-range and zero sizes.
  function automatic logic [15:0] rand_dim(int big);
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return 16'($urandom);
    if (roll < 8) return 16'd0;
    return 16'($urandom_range(1, 1 << $urandom_range(2, big)));
  endfunction

  function automatic req_t rand_word(int big);
    int roll;
    logic signed [63:0] id;
    logic [2:0] op;
    roll = $urandom_range(99);
    id = ($urandom_range(99) < 6) ? {$urandom, $urandom} : key_pool[$urandom_range(NKEYS - 1)];
    if (roll < 45) op = REQ_PUT;
    else if (roll < 75) op = REQ_GET;
    else if (roll < 85) op = REQ_CONTAINS;
    else if (roll < 95) op = REQ_REMOVE;
    else if (roll < 97) op = REQ_CLEAR;
    else op = 3'($urandom_range(5, 7));
    return mk(op, id, rand_dim(big), rand_dim(big));
  endfunction

  task automatic wait_idle();
    wait (pending_words.size() == 0 && !start && expected_rsp.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [11:0] val);
    int seen;
    wait_idle();
    @(negedge clk);
    seen = cfg_writes;
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    wait (cfg_writes != seen);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_phase(logic [11:0] budget, logic [11:0] entries, int pct,
                           int count, int big);
    write_reg(CFG_BUDGET, budget);
    write_reg(CFG_ENTRIES, entries);
    for (int i = 0; i < NKEYS; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = 64'sh8000_0000_0000_0000;
    key_pool[1] = 64'sh7FFF_FFFF_FFFF_FFFF;
    idle_pct = pct;
    for (int i = 0; i < count; i++) pending_words.push_back(rand_word(big));
    wait_idle();   // sender holds until every response is back
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed words at reset settings (64 MiB, 16 slots).
    idle_pct = 28;
    pending_words.push_back(mk(REQ_GET, 64'sd5, 16'd0, 16'd0));          // get miss
    pending_words.push_back(mk(REQ_PUT, 64'sd5, 16'd0, 16'd10));         // zero width
    pending_words.push_back(mk(REQ_PUT, 64'sd5, 16'd10, 16'd0));         // zero height
    pending_words.push_back(mk(REQ_PUT, 64'sd5, 16'hFFFF, 16'hFFFF));    // over budget
    pending_words.push_back(mk(REQ_PUT, 64'sh8000_0000_0000_0000, 16'd1, 16'd1));
    pending_words.push_back(mk(REQ_PUT, 64'sh7FFF_FFFF_FFFF_FFFF, 16'd4096, 16'd4096));
    pending_words.push_back(mk(REQ_PUT, 64'sd5, 16'd2048, 16'd2048));    // 16 MiB
    pending_words.push_back(mk(REQ_GET, 64'sh8000_0000_0000_0000, 16'd0, 16'd0));
    pending_words.push_back(mk(REQ_PUT, 64'sd5, 16'd100, 16'd3));        // resize hit
    pending_words.push_back(mk(REQ_PUT, 64'sd5, 16'd100, 16'd3));        // same size hit
    pending_words.push_back(mk(REQ_PUT, 64'sd6, 16'd4096, 16'd4096));    // evicts LRU
    pending_words.push_back(mk(REQ_CONTAINS, 64'sh7FFF_FFFF_FFFF_FFFF, 16'd0, 16'd0));
    pending_words.push_back(mk(REQ_CONTAINS, 64'sd5, 16'd0, 16'd0));
    pending_words.push_back(mk(REQ_REMOVE, 64'sd5, 16'd0, 16'd0));
    pending_words.push_back(mk(REQ_REMOVE, 64'sd5, 16'd0, 16'd0));       // remove miss
    pending_words.push_back(mk(3'd5, 64'sd6, 16'd1, 16'd1));             // unknown codes
    pending_words.push_back(mk(3'd7, -64'sd1, 16'hFFFF, 16'hFFFF));
    pending_words.push_back(mk(REQ_GET, 64'sd6, 16'd0, 16'd0));
    pending_words.push_back(mk(REQ_CLEAR, 64'sd0, 16'd0, 16'd0));
    pending_words.push_back(mk(REQ_GET, 64'sd6, 16'd0, 16'd0));
    wait_idle();

    // Small budget and few slots: eviction on budget and on full table.
    run_phase(12'd1, 12'd4, 67, 100, 9);
    // Largest budget, all slots.
    run_phase(12'd4095, 12'd16, 0, 100, 13);
    // One slot, tight budget.
    run_phase(12'd2, 12'd1, 28, 80, 9);
    // No slot scanned: every lookup misses, every put fails.
    run_phase(12'd8, 12'd0, 67, 30, 10);
    // Scan range above SLOTS saturates; slots left from earlier still count bytes.
    run_phase(12'd3, 12'd31, 0, 100, 9);
    // Shrink scan range with live entries beyond it, then back to reset values.
    run_phase(12'd16, 12'd7, 28, 90, 11);
    run_phase(12'd64, 12'd16, 0, 100, 11);

    wait_idle();
    if (mismatches == 0 && expected_rsp.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
